### rtl/serial_command_line_parser_defines.svh
// Assertion macros shared by the verification files of the command line parser.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef SERIAL_COMMAND_LINE_PARSER_DEFINES_SVH
`define SERIAL_COMMAND_LINE_PARSER_DEFINES_SVH

// Property that must hold in the same cycle as its antecedent.
`define SCLP_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);

// Property that must hold in the cycle after its antecedent.
`define SCLP_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error(msg);

// Property that must hold later than its antecedent, after a delay.
`define SCLP_ASSERT_LATER(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> ##2 (cons)) \
    else $error(msg);

`endif

### rtl/sclp_pkg.sv
// Shared types, codes and keyword constants of the serial command line parser.
// No dependencies; every module file of the block imports this package.
package sclp_pkg;

  localparam int MAX_LINE = 64;

  localparam int KW_COUNT = 4;
  localparam int KW_MAX   = 12;
  localparam int POS_W    = 4;

  localparam logic [POS_W-1:0] POS_SAT = POS_W'(KW_MAX + 1);

  localparam logic [2:0] CODE_PENDING   = 3'd0;
  localparam logic [2:0] CODE_EMPTY     = 3'd1;
  localparam logic [2:0] CODE_COMMAND   = 3'd2;
  localparam logic [2:0] CODE_UNKNOWN   = 3'd3;
  localparam logic [2:0] CODE_MALFORMED = 3'd4;
  localparam logic [2:0] CODE_TOO_LONG  = 3'd5;

  localparam logic [2:0] CMD_NONE = 3'd0;

  localparam logic [1:0] CAUSE_NONE      = 2'd0;
  localparam logic [1:0] CAUSE_MALFORMED = 2'd1;
  localparam logic [1:0] CAUSE_TOO_LONG  = 2'd2;

  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TILDE = 8'h7E;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_Z  = 8'h5A;

  // Keywords are left aligned: character i sits at bits (KW_MAX-1-i)*8 +: 8.
  localparam logic [KW_MAX*8-1:0] KW_TEXT [KW_COUNT] = '{
    {"status", {6{8'h00}}},
    "album-status",
    {"voice-tap", {3{8'h00}}},
    {"aigc-test", {3{8'h00}}}
  };

  localparam logic [POS_W-1:0] KW_LEN [KW_COUNT] = '{4'd6, 4'd12, 4'd9, 4'd9};

  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

endpackage

### rtl/sclp_datapath.sv
// Datapath of the command line parser: line state, trimmed keyword window and result.
// Depends on sclp_pkg; driven by sclp_ctrl through a dp_cmd_t command.
module sclp_datapath import sclp_pkg::*; #(
  parameter int MaxLine = MAX_LINE
) (
  input  logic       clk,
  input  logic       rst_n,
  input  dp_cmd_t    cmd,
  input  logic [7:0] rx_byte,
  output logic [2:0] parse_code,
  output logic [2:0] command_id
);

  localparam int LenW = $clog2(MaxLine + 1);

  logic [7:0]       byte_r;
  logic [LenW-1:0]  len_r, len_nxt;
  logic [1:0]       cause_r, cause_nxt;
  logic             seen_r, seen_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] trim_r, trim_nxt;
  logic [7:0]       chars_r [KW_MAX];
  logic [2:0]       code_r, code_nxt;
  logic [2:0]       cmd_id_r, cmd_id_nxt;

  logic             is_lf, is_cr, printable, is_space, wr_en;
  logic [7:0]       folded;
  logic [KW_COUNT-1:0] hit;
  logic [2:0]       match_id;

  assign is_lf     = (byte_r == CHAR_LF);
  assign is_cr     = (byte_r == CHAR_CR);
  assign printable = (byte_r >= CHAR_SPACE) && (byte_r <= CHAR_TILDE);
  assign folded    = ((byte_r >= CHAR_UC_A) && (byte_r <= CHAR_UC_Z)) ?
                     (byte_r | CHAR_SPACE) : byte_r;
  assign is_space  = (folded == CHAR_SPACE);

  always_comb begin
    for (int k = 0; k < KW_COUNT; k++) begin
      hit[k] = (trim_r == KW_LEN[k]);
      for (int i = 0; i < KW_MAX; i++) begin
        if ((POS_W'(i) < KW_LEN[k]) &&
            (chars_r[i] != KW_TEXT[k][(KW_MAX-1-i)*8 +: 8])) begin
          hit[k] = 1'b0;
        end
      end
    end
    match_id = CMD_NONE;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (hit[k]) begin
        match_id = 3'(k + 1);
      end
    end
  end

  always_comb begin
    len_nxt    = len_r;
    cause_nxt  = cause_r;
    seen_nxt   = seen_r;
    pos_nxt    = pos_r;
    trim_nxt   = trim_r;
    code_nxt   = CODE_PENDING;
    cmd_id_nxt = CMD_NONE;
    wr_en      = 1'b0;
    if (is_lf) begin
      if (cause_r == CAUSE_TOO_LONG) begin
        code_nxt = CODE_TOO_LONG;
      end else if (cause_r == CAUSE_MALFORMED) begin
        code_nxt = CODE_MALFORMED;
      end else if (!seen_r) begin
        code_nxt = CODE_EMPTY;
      end else if (match_id != CMD_NONE) begin
        code_nxt   = CODE_COMMAND;
        cmd_id_nxt = match_id;
      end else begin
        code_nxt = CODE_UNKNOWN;
      end
      len_nxt   = '0;
      cause_nxt = CAUSE_NONE;
      seen_nxt  = 1'b0;
      pos_nxt   = '0;
      trim_nxt  = '0;
    end else if (!is_cr && (cause_r == CAUSE_NONE)) begin
      if (!printable) begin
        cause_nxt = CAUSE_MALFORMED;
      end else if (len_r >= LenW'(MaxLine)) begin
        cause_nxt = CAUSE_TOO_LONG;
      end else begin
        len_nxt = len_r + 1'b1;
        if (seen_r || !is_space) begin
          seen_nxt = 1'b1;
          wr_en    = (pos_r < POS_W'(KW_MAX));
          pos_nxt  = (pos_r == POS_SAT) ? pos_r : pos_r + 1'b1;
          if (!is_space) begin
            trim_nxt = pos_nxt;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      cause_r <= CAUSE_NONE;
      seen_r  <= 1'b0;
      pos_r   <= '0;
      trim_r  <= '0;
    end else if (cmd.exec) begin
      len_r   <= len_nxt;
      cause_r <= cause_nxt;
      seen_r  <= seen_nxt;
      pos_r   <= pos_nxt;
      trim_r  <= trim_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r <= rx_byte;
    end
    if (cmd.exec) begin
      code_r   <= code_nxt;
      cmd_id_r <= cmd_id_nxt;
      if (wr_en) begin
        chars_r[pos_r] <= folded;
      end
    end
  end

  assign parse_code = code_r;
  assign command_id = cmd_id_r;

endmodule

### rtl/sclp_ctrl.sv
// Controller of the command line parser: input and result handshakes, datapath commands.
// Depends on sclp_pkg for the dp_cmd_t command type.
module sclp_ctrl import sclp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  output dp_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign cmd.load   = in_tvalid && in_tready;
  assign cmd.exec   = (state_r == S_EXEC);

endmodule

### rtl/serial_command_line_parser.sv
// Serial command line parser: one received byte in, one parse result out per item.
// Usage:
// The input stream carries one raw serial byte per item in in_tdata. Every byte
// yields exactly one result item on the output stream. Bytes other than line feed
// give the pending code; a line feed classifies the buffered line as empty,
// unknown, malformed, too long or one of four commands, then clears the line.
// An item passes the controller states in order: the byte is captured on
// acceptance in idle, the line state and result register update in exec, and
// the result is offered in out. The controller handles one item at a time,
// so the input accepts a new byte only after the previous result was taken.
// Keyword matching is done combinationally on a twelve-character window, so a
// line feed takes no longer than any other byte. When out_tready is low the
// result holds and in_tready stays low.
// Reset clears the line state at once; no clearing pass is needed.
// Depends on sclp_pkg, sclp_ctrl and sclp_datapath.
module serial_command_line_parser import sclp_pkg::*; #(
  parameter int MaxLine = MAX_LINE
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [2:0] parse_code, [5:3] command_id, [7:6] zero
);

  dp_cmd_t    cmd;
  logic [2:0] parse_code;
  logic [2:0] command_id;

  sclp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  sclp_datapath #(
    .MaxLine (MaxLine)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .rx_byte    (in_tdata),
    .parse_code (parse_code),
    .command_id (command_id)
  );

  assign out_tdata = {2'b00, command_id, parse_code};

endmodule

### rtl/sclp_checker.sv
// Port-level assertions for the serial command line parser, bound to the top level.
// Depends on sclp_pkg and serial_command_line_parser_defines.svh.
`include "serial_command_line_parser_defines.svh"

module sclp_checker import sclp_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  `SCLP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")
  `SCLP_ASSERT_NOW(a_one_at_a_time, out_tvalid, !in_tready, "input ready while a result waits")
  `SCLP_ASSERT_NOW(a_code_legal, out_tvalid, (out_tdata[7:6] == 2'b00) && (out_tdata[2:0] <= CODE_TOO_LONG) && ((out_tdata[5:3] == CMD_NONE) || (out_tdata[2:0] == CODE_COMMAND)), "illegal result encoding")
  `SCLP_ASSERT_LATER(a_pending, in_tvalid && in_tready && (in_tdata != CHAR_LF), out_tvalid && (out_tdata[5:0] == 6'd0), "non line feed byte did not give pending")

endmodule

bind serial_command_line_parser sclp_checker u_sclp_checker (.*);
